@@ sv/dtoi_pkg.sv @@
// dtoi_pkg: shared types and constants for the decimal text to int32 parser
// no dependencies; used by dtoi_parser, dtoi_out_reg and decimal_text_to_int32
package dtoi_pkg;

  localparam int unsigned ValueW = 32;
  localparam int unsigned AccW   = 36;  // magnitude * 10 + 9 fits below 2^36

  // character codes
  localparam logic [7:0] ChNul   = 8'd0;
  localparam logic [7:0] ChTab   = 8'd9;
  localparam logic [7:0] ChCr    = 8'd13;
  localparam logic [7:0] ChSpace = 8'd32;
  localparam logic [7:0] ChPlus  = 8'd43;
  localparam logic [7:0] ChMinus = 8'd45;
  localparam logic [7:0] ChZero  = 8'd48;
  localparam logic [7:0] ChNine  = 8'd57;

  // largest positive magnitude, one more is allowed when negative
  localparam logic [AccW-1:0] PosLimit = AccW'(64'd2147483647);

  // one finished result word
  typedef struct packed {
    logic signed [ValueW-1:0] value;
    logic                     parse_error;
  } result_t;

endpackage

@@ sv/dtoi_parser.sv @@
// dtoi_parser: per-character parse state and the multiply-by-ten accumulator
// depends on dtoi_pkg
module dtoi_parser (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  logic [7:0]         char_i,
  output logic               res_valid_o,
  output dtoi_pkg::result_t  res_o
);

  typedef enum logic [1:0] {
    PhLead   = 2'd0,
    PhSign   = 2'd1,
    PhDigits = 2'd2,
    PhSkip   = 2'd3
  } phase_e;

  phase_e                          phase_q, phase_d;
  logic [dtoi_pkg::ValueW-1:0]     mag_q, mag_d;
  logic                            neg_q, neg_d;
  logic                            err_q, err_d;
  logic                            ovf_q, ovf_d;

  logic                            is_nul, is_digit, is_space, is_sign;
  logic [dtoi_pkg::AccW-1:0]       acc_next, limit;
  logic                            acc_over;

  // character classes
  assign is_nul   = (char_i == dtoi_pkg::ChNul);
  assign is_digit = (char_i >= dtoi_pkg::ChZero) && (char_i <= dtoi_pkg::ChNine);
  assign is_space = ((char_i >= dtoi_pkg::ChTab) && (char_i <= dtoi_pkg::ChCr)) ||
                    (char_i == dtoi_pkg::ChSpace);
  assign is_sign  = (char_i == dtoi_pkg::ChPlus) || (char_i == dtoi_pkg::ChMinus);

  // magnitude * 10 + digit as two shifts and adds
  assign acc_next = ({4'b0, mag_q} << 3) + ({4'b0, mag_q} << 1) +
                    dtoi_pkg::AccW'(char_i - dtoi_pkg::ChZero);
  assign limit    = dtoi_pkg::PosLimit + dtoi_pkg::AccW'(neg_q);
  assign acc_over = (acc_next > limit);

  // result at the terminating nul
  assign res_valid_o = accept_i && is_nul;
  always_comb begin
    res_o.parse_error = err_q || ovf_q || (phase_q == PhLead) || (phase_q == PhSign);
    if (ovf_q) begin
      res_o.value = '0;
    end else if (neg_q) begin
      res_o.value = $signed(-mag_q);
    end else begin
      res_o.value = $signed(mag_q);
    end
  end

  // next parse state
  always_comb begin
    phase_d = phase_q;
    mag_d   = mag_q;
    neg_d   = neg_q;
    err_d   = err_q;
    ovf_d   = ovf_q;
    if (is_nul) begin
      phase_d = PhLead;
      mag_d   = '0;
      neg_d   = 1'b0;
      err_d   = 1'b0;
      ovf_d   = 1'b0;
    end else begin
      case (phase_q)
        PhLead, PhSign, PhDigits: begin
          if (is_digit) begin
            if (acc_over) begin
              ovf_d   = 1'b1;
              phase_d = PhSkip;
            end else begin
              mag_d   = acc_next[dtoi_pkg::ValueW-1:0];
              phase_d = PhDigits;
            end
          end else if ((phase_q == PhLead) && is_space) begin
            phase_d = PhLead;
          end else if ((phase_q == PhLead) && is_sign) begin
            neg_d   = (char_i == dtoi_pkg::ChMinus);
            phase_d = PhSign;
          end else begin
            err_d   = 1'b1;
            phase_d = PhSkip;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhLead;
      mag_q   <= '0;
      neg_q   <= 1'b0;
      err_q   <= 1'b0;
      ovf_q   <= 1'b0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      mag_q   <= mag_d;
      neg_q   <= neg_d;
      err_q   <= err_d;
      ovf_q   <= ovf_d;
    end
  end

endmodule

@@ sv/dtoi_out_reg.sv @@
// dtoi_out_reg: result register holding one word for the output channel
// depends on dtoi_pkg
module dtoi_out_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  dtoi_pkg::result_t  res_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic               space_o,
  output dtoi_pkg::result_t  res_o
);

  logic              valid_q, valid_d;
  dtoi_pkg::result_t data_q;

  // room when empty or draining this cycle
  assign space_o = !valid_q || out_ready_i;
  assign valid_d = load_i || (valid_q && !out_ready_i);

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = data_q;

endmodule

@@ sv/decimal_text_to_int32.sv @@
// decimal_text_to_int32: strict decimal text to signed 32-bit integer parser
// depends on dtoi_pkg, dtoi_parser and dtoi_out_reg
//
// Usage: send one ASCII character per input word on char_byte_i with
// valid/ready. Leading whitespace is skipped, one optional sign may follow,
// then digits. A nul character ends the string and produces exactly one
// output word (value_o, parse_error_o); other characters produce none.
// One character per cycle is taken while in_ready_o is high: the parse state
// and the multiply-by-ten accumulator update in the cycle a character is
// taken. The result appears in the cycle after the nul is accepted, from a
// single result register. While that register holds a word the receiver has
// not taken, in_ready_o stays low; it rises again in the cycle the word is
// taken, so a ready receiver sees no bubble. Reset clears the parse state
// and empties the result register; no result is pending after reset.
module decimal_text_to_int32 (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         char_byte_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] value_o,
  output logic               parse_error_o
);

  logic              in_accept;
  logic              res_valid;
  dtoi_pkg::result_t res_word;
  dtoi_pkg::result_t out_word;
  logic              space;

  assign in_ready_o = space;
  assign in_accept  = in_valid_i && in_ready_o;

  // character parser
  dtoi_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (in_accept),
    .char_i      (char_byte_i),
    .res_valid_o (res_valid),
    .res_o       (res_word)
  );

  // output word register
  dtoi_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (res_valid),
    .res_i       (res_word),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .space_o     (space),
    .res_o       (out_word)
  );

  assign value_o       = out_word.value;
  assign parse_error_o = out_word.parse_error;

  // a terminating nul always yields a pending result next cycle
  a_nul_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && (char_byte_i == dtoi_pkg::ChNul) |=> out_valid_o)
    else $error("nul accepted but no result pending");

  // ordinary characters never create a result
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && (char_byte_i != dtoi_pkg::ChNul) && !out_valid_o |=> !out_valid_o)
    else $error("result appeared without a nul");

  // a stalled result blocks input so it cannot be overwritten
  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input accepted while result stalled");

  // a stalled result word holds steady until taken
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(value_o) && $stable(parse_error_o))
    else $error("stalled result word changed");

endmodule
